// ----- design/nsq_pkg.sv -----
// Package with shared types and constants for the nearest segment query unit.
`default_nettype none
package nsq_pkg;
   localparam int CoordWidth = 32;
   localparam int DistWidth  = 34;
   localparam int CountWidth = 9;
   localparam int IndexWidth = 8;
   // Depth of the segment table and the width of a slot address into it.
   localparam int MaxSegments = 256;
   localparam int SlotWidth = 8;
   localparam logic KindWrite = 1'b0;
   localparam logic KindQuery = 1'b1;
   localparam logic [1:0] AddrSegmentCount = 2'd0;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [DistWidth-1:0] dist_type;

   typedef struct packed {
      logic       kind;
      logic [IndexWidth-1:0] entry_index;
      coord_type  start_x;
      coord_type  start_y;
      coord_type  start_z;
      coord_type  end_x;
      coord_type  end_y;
      coord_type  end_z;
      coord_type  query_x;
      coord_type  query_y;
      coord_type  query_z;
   } req_type;

   typedef struct packed {
      logic      found;
      dist_type  min_distance;
      coord_type near_x;
      coord_type near_y;
      coord_type near_z;
   } rsp_type;

   // Status that the search engine hands to the result stage.
   typedef struct packed {
      logic   done;
      logic   found;
      logic [133:0] best_dist2;
      coord_type near_x;
      coord_type near_y;
      coord_type near_z;
   } search_type;
endpackage
`default_nettype wire

// ----- design/nsq_if.sv -----
// Valid/ready channel interface that carries one item.
`default_nettype none
interface nsq_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/nsq_divider.sv -----
// Restoring divider that forms the Q1.32 projection parameter one bit a cycle.
`default_nettype none
module nsq_divider (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [97:0]  dot,
   input  wire logic [97:0]  len2,
   output logic              done,
   output logic [32:0]       quotient
);
   logic [98:0] rem_ff, rem_in;
   logic [97:0] den_ff;
   logic [32:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [98:0] shifted;

   always_comb begin
      shifted = {rem_ff[97:0], 1'b0};
      rem_in = shifted;
      quo_in = {quo_ff[31:0], 1'b0};
      if (shifted >= {1'b0, den_ff}) begin
         rem_in = shifted - {1'b0, den_ff};
         quo_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      done <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         if (dot == len2) begin
            quo_ff <= 33'h1_0000_0000;
            done <= 1'b1;
         end else begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= {1'b0, dot};
            den_ff <= len2;
            quo_ff <= '0;
         end
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_ff <= 1'b0;
            done <= 1'b1;
         end
      end
   end
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ----- design/nsq_sqrt.sv -----
// Bit-serial integer square root of the best squared distance.
`default_nettype none
module nsq_sqrt (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [133:0]  radicand,
   output logic               done,
   output logic [33:0]        root
);
   logic [33:0]  res_ff;
   logic [133:0] rad_ff;
   logic [5:0]   bit_ff;
   logic         busy_ff;
   logic [33:0]  cand;
   logic [67:0]  sq;

   always_comb begin
      cand = res_ff | (34'd1 << bit_ff);
      sq = cand * cand;
   end

   always_ff @(posedge clock) begin
      done <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         bit_ff <= 6'd33;
         res_ff <= '0;
         rad_ff <= radicand;
      end else if (busy_ff) begin
         if ({66'd0, sq} <= rad_ff) res_ff <= cand;
         if (bit_ff == 6'd0) begin
            busy_ff <= 1'b0;
            done <= 1'b1;
         end else begin
            bit_ff <= bit_ff - 6'd1;
         end
      end
   end
   assign root = res_ff;
endmodule
`default_nettype wire

// ----- design/nsq_search.sv -----
// Segment memory and the sequencer that tests each stored segment in turn.
`default_nettype none
module nsq_search (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     write_en,
   input  wire logic [nsq_pkg::SlotWidth-1:0] write_slot,
   input  wire logic [6*32-1:0]          write_data,
   input  wire logic                     query_start,
   input  wire nsq_pkg::coord_type       qx,
   input  wire nsq_pkg::coord_type       qy,
   input  wire nsq_pkg::coord_type       qz,
   input  wire logic [nsq_pkg::CountWidth-1:0] count,
   output nsq_pkg::search_type           status
);
   localparam int CntW = $clog2(nsq_pkg::MaxSegments + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_DIFF, S_MUL, S_SUM, S_CHECK, S_DIV, S_FOOT, S_FOOT2, S_DIST,
      S_DIST2, S_CMP, S_DONE
   } state_type;

   logic [6*32-1:0] mem [nsq_pkg::MaxSegments];
   logic [6*32-1:0] rd_ff;
   state_type       state_ff;
   logic [CntW-1:0] idx_ff, limit_ff;
   logic signed [32:0] d_ff [3], w_ff [3];
   logic [65:0] dd_ff [3];
   logic signed [66:0] wd_ff [3];
   logic [67:0] len2_ff;
   logic signed [68:0] dot_ff;
   logic [32:0] u_ff;
   logic signed [32:0] off_ff [3];
   nsq_pkg::coord_type f_ff [3];
   logic [65:0] e2_ff [3];
   logic [67:0] dist2_ff;
   logic        div_start, div_done;
   logic [32:0] div_q;
   logic        found_ff;
   logic [67:0] best_ff;
   logic signed [31:0] bx_ff, by_ff, bz_ff;
   logic        done_ff;
   // Marks that the segment under test qualified and reached the distance stage.
   logic        u_valid_ff;

   always_ff @(posedge clock) begin
      if (write_en) mem[write_slot] <= write_data;
      rd_ff <= mem[idx_ff[nsq_pkg::SlotWidth-1:0]];
   end

   nsq_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dot({30'd0, dot_ff[67:0]}), .len2({30'd0, len2_ff}),
      .done(div_done), .quotient(div_q)
   );
   assign div_start = (state_ff == S_CHECK) && (len2_ff != '0) && !dot_ff[68]
      && ($unsigned(dot_ff[67:0]) <= len2_ff);

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (query_start) begin
               idx_ff <= '0;
               found_ff <= 1'b0;
               best_ff <= '0;
               bx_ff <= '0; by_ff <= '0; bz_ff <= '0;
               limit_ff <= ({1'b0, count} > 10'(nsq_pkg::MaxSegments))
                           ? CntW'(nsq_pkg::MaxSegments) : CntW'(count);
               state_ff <= S_READ;
            end
            S_READ: state_ff <= (idx_ff == limit_ff) ? S_DONE : S_DIFF;
            S_DIFF: begin
               for (int i = 0; i < 3; i++) begin
                  d_ff[i] <= 33'(signed'(rd_ff[32*(3+i) +: 32]))
                           - 33'(signed'(rd_ff[32*i +: 32]));
               end
               w_ff[0] <= 33'(qx) - 33'(signed'(rd_ff[31:0]));
               w_ff[1] <= 33'(qy) - 33'(signed'(rd_ff[63:32]));
               w_ff[2] <= 33'(qz) - 33'(signed'(rd_ff[95:64]));
               state_ff <= S_MUL;
            end
            S_MUL: begin
               for (int i = 0; i < 3; i++) begin
                  dd_ff[i] <= 66'(d_ff[i] * d_ff[i]);
                  wd_ff[i] <= w_ff[i] * d_ff[i];
               end
               state_ff <= S_SUM;
            end
            S_SUM: begin
               len2_ff <= 68'(dd_ff[0]) + 68'(dd_ff[1]) + 68'(dd_ff[2]);
               dot_ff <= 69'(wd_ff[0]) + 69'(wd_ff[1]) + 69'(wd_ff[2]);
               state_ff <= S_CHECK;
            end
            S_CHECK: state_ff <= div_start ? S_DIV : S_CMP;
            S_DIV: if (div_done) begin
               u_ff <= div_q;
               state_ff <= S_FOOT;
            end
            S_FOOT: begin
               for (int i = 0; i < 3; i++) begin
                  logic [32:0] mg;
                  logic [65:0] pr;
                  mg = d_ff[i][32] ? 33'(-d_ff[i]) : 33'(d_ff[i]);
                  pr = 66'(mg) * 66'(u_ff) + 66'h8000_0000;
                  off_ff[i] <= d_ff[i][32] ? -signed'(33'(pr[65:32]))
                                           : signed'(33'(pr[65:32]));
               end
               state_ff <= S_FOOT2;
            end
            S_FOOT2: begin
               for (int i = 0; i < 3; i++)
                  f_ff[i] <= 32'(33'(signed'(rd_ff[32*i +: 32])) + off_ff[i]);
               state_ff <= S_DIST;
            end
            S_DIST: begin
               e2_ff[0] <= 66'((33'(qx) - 33'(f_ff[0])) * (33'(qx) - 33'(f_ff[0])));
               e2_ff[1] <= 66'((33'(qy) - 33'(f_ff[1])) * (33'(qy) - 33'(f_ff[1])));
               e2_ff[2] <= 66'((33'(qz) - 33'(f_ff[2])) * (33'(qz) - 33'(f_ff[2])));
               state_ff <= S_DIST2;
            end
            S_DIST2: begin
               dist2_ff <= 68'(e2_ff[0]) + 68'(e2_ff[1]) + 68'(e2_ff[2]);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (u_valid_ff && (!found_ff || dist2_ff < best_ff)) begin
                  found_ff <= 1'b1;
                  best_ff <= dist2_ff;
                  bx_ff <= f_ff[0]; by_ff <= f_ff[1]; bz_ff <= f_ff[2];
               end
               idx_ff <= idx_ff + 1'b1;
               state_ff <= S_READ;
            end
            S_DONE: begin
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) u_valid_ff <= 1'b0;
      else if (state_ff == S_CHECK) u_valid_ff <= div_start;
   end

   assign status.done = done_ff;
   assign status.found = found_ff;
   assign status.best_dist2 = {66'd0, best_ff};
   assign status.near_x = bx_ff;
   assign status.near_y = by_ff;
   assign status.near_z = bz_ff;

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |=> idx_ff <= limit_ff) else $error("index past count");
   a_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("stray divider result");
   a_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == S_DONE) else $error("stray done");
`endif
endmodule
`default_nettype wire

// ----- design/nearest_segment_query_unit.sv -----
// Top level of the nearest segment query unit.
// Channel   | Direction | Contents
// req       | in        | segment write (kind 0) or query point (kind 1)
// rsp       | out       | found flag, distance and foot point per query
// csr       | in (APB)  | segment_count register at address 0
// A write item is stored directly in the segment memory. A query tests each searched
// segment in turn; a segment that qualifies also goes through the 32 steps of the single
// bit-serial divider (skipped when the point projects exactly onto the end point), and a
// square root of the best squared distance follows when one qualified.
// Reset is synchronous and clears the sequencers and segment_count; the memory
// holds no reset value. One item is worked at a time; a stalled result holds
// in the output register while the next item is taken, and a finished query
// waits for that register to free up before it presents its own result.
`default_nettype none
module nearest_segment_query_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   nsq_if.sink        req,
   nsq_if.source      rsp,
   input  wire logic  csr_psel,
   input  wire logic  csr_penable,
   input  wire logic  csr_pwrite,
   input  wire logic  [1:0] csr_paddr,
   input  wire logic  [31:0] csr_pwdata,
   output logic       [31:0] csr_prdata,
   output logic       csr_pready
);
   typedef enum logic [1:0] {T_IDLE, T_SEARCH, T_ROOT, T_OUT} top_state_type;

   logic [nsq_pkg::CountWidth-1:0] count_ff;
   top_state_type state_ff;
   nsq_pkg::req_type req_ff;
   nsq_pkg::search_type status;
   nsq_pkg::rsp_type res_ff;
   nsq_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic sent_ff;
   logic accept, wr_en, q_start, root_done, out_free;
   logic [33:0] root;

   assign csr_pready = 1'b1;
   assign csr_prdata = {23'd0, count_ff};
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (csr_psel && csr_penable && csr_pwrite
               && csr_paddr == nsq_pkg::AddrSegmentCount)
         count_ff <= csr_pwdata[nsq_pkg::CountWidth-1:0];
   end

   // Items are taken only while idle; the output register decouples the sink.
   assign req.ready = (state_ff == T_IDLE);
   assign accept = req.valid && req.ready;
   assign wr_en = accept && req.payload.kind == nsq_pkg::KindWrite
      && {1'b0, req.payload.entry_index} < 9'(nsq_pkg::MaxSegments);
   assign q_start = accept && req.payload.kind == nsq_pkg::KindQuery;
   // The output register can take a new result when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) if (q_start) req_ff <= req.payload;

   nsq_search u_search (
      .clock(clock), .reset(reset), .write_en(wr_en),
      .write_slot(req.payload.entry_index),
      .write_data({req.payload.end_z, req.payload.end_y, req.payload.end_x,
                   req.payload.start_z, req.payload.start_y, req.payload.start_x}),
      .query_start(state_ff == T_SEARCH && !sent_ff),
      .qx(req_ff.query_x), .qy(req_ff.query_y), .qz(req_ff.query_z),
      .count(count_ff), .status(status)
   );

   nsq_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(status.done && status.found),
      .radicand(status.best_dist2), .done(root_done), .root(root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         sent_ff <= 1'b0;
      end else begin
         if (state_ff == T_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            T_IDLE: if (q_start) begin
               state_ff <= T_SEARCH;
               sent_ff <= 1'b0;
            end
            T_SEARCH: begin
               sent_ff <= 1'b1;
               if (status.done) begin
                  if (status.found) begin
                     state_ff <= T_ROOT;
                     res_ff.near_x <= status.near_x;
                     res_ff.near_y <= status.near_y;
                     res_ff.near_z <= status.near_z;
                  end else begin
                     res_ff <= '0;
                     state_ff <= T_OUT;
                  end
               end
            end
            T_ROOT: if (root_done) begin
               res_ff.found <= 1'b1;
               res_ff.min_distance <= root;
               state_ff <= T_OUT;
            end
            T_OUT: if (out_free) begin
               rsp_ff <= res_ff;
               state_ff <= T_IDLE;
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

`ifndef SYNTHESIS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != T_IDLE |-> !req.ready) else $error("ready while busy");
   a_one: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == T_ROOT) else $error("stray root");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff) else $error("result lost");
`endif
endmodule
`default_nettype wire
